// ===== hdl/i2cdiv_pkg.sv =====
package i2cdiv_pkg;

	// Field widths fixed by the interface.
	localparam int unsigned CLK_W     = 32;
	localparam int unsigned RATE_W    = 28;
	localparam int unsigned MULT_W    = 2;
	localparam int unsigned DIDX_W    = 6;
	localparam int unsigned BASE_W    = 12;
	localparam int unsigned DIVISOR_W = 14;
	localparam int unsigned CNT_W     = 5;
	localparam int unsigned STEP_W    = 3;

	localparam logic [CLK_W-1:0]  MODULE_CLOCK_RESET = 32'd50000000;
	localparam logic [MULT_W-1:0] MULT_LAST          = 2'd2;
	localparam logic [DIDX_W-1:0] DIDX_LAST          = 6'd63;
	localparam logic [CNT_W-1:0]  CNT_LAST           = 5'd31;

	typedef logic [STEP_W-1:0] step_t;

	// Program addresses.
	localparam step_t STEP_IDLE = 3'd0;
	localparam step_t STEP_INIT = 3'd1;
	localparam step_t STEP_LOAD = 3'd2;
	localparam step_t STEP_DIV  = 3'd3;
	localparam step_t STEP_CMP  = 3'd4;
	localparam step_t STEP_ADV  = 3'd5;
	localparam step_t STEP_DONE = 3'd6;

	// Jump conditions; a true condition loads the target, otherwise the step advances.
	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_START,
		COND_DIV_MORE,
		COND_PAIR_MORE
	} cond_t;

	// One control word of the program.
	typedef struct packed {
		logic  init;
		logic  load;
		logic  div_step;
		logic  update;
		logic  advance;
		logic  emit;
		cond_t cond;
		step_t target;
	} ctl_t;

	// The program itself.
	function automatic ctl_t ucode(input step_t step);
		ctl_t w;
		w = '0;
		w.cond = COND_NEVER;
		w.target = STEP_IDLE;
		case (step)
			STEP_IDLE: begin
				w.cond = COND_NO_START;
				w.target = STEP_IDLE;
			end
			STEP_INIT: begin
				w.init = 1'b1;
			end
			STEP_LOAD: begin
				w.load = 1'b1;
			end
			STEP_DIV: begin
				w.div_step = 1'b1;
				w.cond = COND_DIV_MORE;
				w.target = STEP_DIV;
			end
			STEP_CMP: begin
				w.update = 1'b1;
			end
			STEP_ADV: begin
				w.advance = 1'b1;
				w.cond = COND_PAIR_MORE;
				w.target = STEP_LOAD;
			end
			STEP_DONE: begin
				w.emit = 1'b1;
				w.cond = COND_ALWAYS;
				w.target = STEP_IDLE;
			end
			default: begin
				w.cond = COND_ALWAYS;
				w.target = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

	// Base divider table, before the multiplier is applied.
	function automatic logic [BASE_W-1:0] div_base(input logic [DIDX_W-1:0] idx);
		logic [BASE_W-1:0] v;
		case (idx)
			6'd0:  v = 12'd20;   6'd1:  v = 12'd22;   6'd2:  v = 12'd24;   6'd3:  v = 12'd26;
			6'd4:  v = 12'd28;   6'd5:  v = 12'd30;   6'd6:  v = 12'd34;   6'd7:  v = 12'd40;
			6'd8:  v = 12'd28;   6'd9:  v = 12'd32;   6'd10: v = 12'd36;   6'd11: v = 12'd40;
			6'd12: v = 12'd44;   6'd13: v = 12'd48;   6'd14: v = 12'd56;   6'd15: v = 12'd68;
			6'd16: v = 12'd48;   6'd17: v = 12'd56;   6'd18: v = 12'd64;   6'd19: v = 12'd72;
			6'd20: v = 12'd80;   6'd21: v = 12'd88;   6'd22: v = 12'd104;  6'd23: v = 12'd128;
			6'd24: v = 12'd80;   6'd25: v = 12'd96;   6'd26: v = 12'd112;  6'd27: v = 12'd128;
			6'd28: v = 12'd144;  6'd29: v = 12'd160;  6'd30: v = 12'd192;  6'd31: v = 12'd240;
			6'd32: v = 12'd160;  6'd33: v = 12'd192;  6'd34: v = 12'd224;  6'd35: v = 12'd256;
			6'd36: v = 12'd288;  6'd37: v = 12'd320;  6'd38: v = 12'd384;  6'd39: v = 12'd480;
			6'd40: v = 12'd320;  6'd41: v = 12'd384;  6'd42: v = 12'd448;  6'd43: v = 12'd512;
			6'd44: v = 12'd576;  6'd45: v = 12'd640;  6'd46: v = 12'd768;  6'd47: v = 12'd960;
			6'd48: v = 12'd640;  6'd49: v = 12'd768;  6'd50: v = 12'd896;  6'd51: v = 12'd1024;
			6'd52: v = 12'd1152; 6'd53: v = 12'd1280; 6'd54: v = 12'd1536; 6'd55: v = 12'd1920;
			6'd56: v = 12'd1280; 6'd57: v = 12'd1536; 6'd58: v = 12'd1792; 6'd59: v = 12'd2048;
			6'd60: v = 12'd2304; 6'd61: v = 12'd2560; 6'd62: v = 12'd3072; 6'd63: v = 12'd3840;
			default: v = 12'd20;
		endcase
		return v;
	endfunction

endpackage

// ===== hdl/i2c_clock_divider_search_core.sv =====
// Serial clock divider search. Pulse start with desired_rate while busy is low; the block
// tries the multipliers x1, x2 and x4 against all 64 divider table entries, dividing
// module_clock by each product, and reports the pair with the smallest absolute rate
// error (the first one found on a tie). The result appears for exactly one cycle with
// done high and cannot be held off, so the receiver must take it then. An item runs
// from the accepting edge through one init step, 192 pairs and one done step, and
// the next item may be accepted the cycle after done: each of the 192 pairs runs the
// microcode program's load, 32 steps of the one-bit-per-cycle restoring divider,
// compare and advance.
// module_clock is written over the cfg_valid/cfg_ready channel while busy is low; it
// resets to 50 MHz.
module i2c_clock_divider_search_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [i2cdiv_pkg::CLK_W-1:0]       desired_rate,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [i2cdiv_pkg::CLK_W-1:0]       cfg_data,
	output logic                               done,
	output logic [i2cdiv_pkg::MULT_W-1:0]      mult_index,
	output logic [i2cdiv_pkg::DIDX_W-1:0]      divider_index,
	output logic [i2cdiv_pkg::RATE_W-1:0]      achieved_rate,
	output logic [i2cdiv_pkg::CLK_W-1:0]       rate_error
);

	i2cdiv_pkg::step_t                  pc_q;
	i2cdiv_pkg::ctl_t                   ctl;
	logic                               take_jump;
	logic                               accept;
	logic [i2cdiv_pkg::CLK_W-1:0]       module_clock_q;
	logic [i2cdiv_pkg::CLK_W-1:0]       desired_q;
	logic [i2cdiv_pkg::MULT_W-1:0]      m_q;
	logic [i2cdiv_pkg::DIDX_W-1:0]      d_q;
	logic [i2cdiv_pkg::CNT_W-1:0]       cnt_q;
	logic [i2cdiv_pkg::DIVISOR_W-1:0]   divisor_q;
	logic [i2cdiv_pkg::DIVISOR_W-1:0]   rem_q;
	logic [i2cdiv_pkg::CLK_W-1:0]       quo_q;
	logic                               first_q;
	logic [i2cdiv_pkg::MULT_W-1:0]      best_m_q;
	logic [i2cdiv_pkg::DIDX_W-1:0]      best_d_q;
	logic [i2cdiv_pkg::RATE_W-1:0]      best_rate_q;
	logic [i2cdiv_pkg::CLK_W-1:0]       best_err_q;
	logic [i2cdiv_pkg::DIVISOR_W:0]     shifted;
	logic [i2cdiv_pkg::DIVISOR_W:0]     trial;
	logic                               fits;
	logic [i2cdiv_pkg::CLK_W-1:0]       rate_ext;
	logic [i2cdiv_pkg::CLK_W-1:0]       err;
	logic [i2cdiv_pkg::DIVISOR_W-1:0]   next_divisor;
	logic                               last_pair;

	// Control word of the current step.
	assign ctl       = i2cdiv_pkg::ucode(pc_q);
	assign busy      = (pc_q != i2cdiv_pkg::STEP_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = !busy;
	assign done      = ctl.emit;
	assign last_pair = (m_q == i2cdiv_pkg::MULT_LAST) && (d_q == i2cdiv_pkg::DIDX_LAST);

	// Jump condition select.
	always_comb begin
		case (ctl.cond)
			i2cdiv_pkg::COND_NEVER:     take_jump = 1'b0;
			i2cdiv_pkg::COND_ALWAYS:    take_jump = 1'b1;
			i2cdiv_pkg::COND_NO_START:  take_jump = !start;
			i2cdiv_pkg::COND_DIV_MORE:  take_jump = (cnt_q != i2cdiv_pkg::CNT_LAST);
			i2cdiv_pkg::COND_PAIR_MORE: take_jump = !last_pair;
			default:                    take_jump = 1'b1;
		endcase
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= i2cdiv_pkg::STEP_IDLE;
		end else if (take_jump) begin
			pc_q <= ctl.target;
		end else begin
			pc_q <= pc_q + i2cdiv_pkg::step_t'(1);
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			module_clock_q <= i2cdiv_pkg::MODULE_CLOCK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			module_clock_q <= cfg_data;
		end
	end

	// Divisor for the current pair, and one restoring division step.
	assign next_divisor = {2'b00, i2cdiv_pkg::div_base(d_q)} << m_q;
	assign shifted      = {rem_q, quo_q[i2cdiv_pkg::CLK_W-1]};
	assign trial        = shifted - {1'b0, divisor_q};
	assign fits         = !trial[i2cdiv_pkg::DIVISOR_W];

	// Absolute error of the quotient just produced.
	assign rate_ext = {{(i2cdiv_pkg::CLK_W-i2cdiv_pkg::RATE_W){1'b0}},
		quo_q[i2cdiv_pkg::RATE_W-1:0]};
	assign err = (rate_ext >= desired_q) ? (rate_ext - desired_q) : (desired_q - rate_ext);

	// Pair indices, divider iteration count and the first-pair flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q     <= '0;
			d_q     <= '0;
			cnt_q   <= '0;
			first_q <= 1'b0;
		end else begin
			if (ctl.init) begin
				m_q     <= '0;
				d_q     <= '0;
				first_q <= 1'b1;
			end
			if (ctl.load) begin
				cnt_q <= '0;
			end
			if (ctl.div_step) begin
				cnt_q <= cnt_q + i2cdiv_pkg::CNT_W'(1);
			end
			if (ctl.update) begin
				first_q <= 1'b0;
			end
			if (ctl.advance) begin
				d_q <= d_q + i2cdiv_pkg::DIDX_W'(1);
				if (d_q == i2cdiv_pkg::DIDX_LAST) begin
					m_q <= m_q + i2cdiv_pkg::MULT_W'(1);
				end
			end
		end
	end

	// Datapath: request capture, divider and best-so-far registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			desired_q <= desired_rate;
		end
		if (ctl.load) begin
			divisor_q <= next_divisor;
			rem_q     <= '0;
			quo_q     <= module_clock_q;
		end
		if (ctl.div_step) begin
			rem_q <= fits ? trial[i2cdiv_pkg::DIVISOR_W-1:0] : shifted[i2cdiv_pkg::DIVISOR_W-1:0];
			quo_q <= {quo_q[i2cdiv_pkg::CLK_W-2:0], fits};
		end
		if (ctl.update && (first_q || (err < best_err_q))) begin
			best_m_q    <= m_q;
			best_d_q    <= d_q;
			best_rate_q <= quo_q[i2cdiv_pkg::RATE_W-1:0];
			best_err_q  <= err;
		end
	end

	// Result ports.
	assign mult_index    = best_m_q;
	assign divider_index = best_d_q;
	assign achieved_rate = best_rate_q;
	assign rate_error    = best_err_q;

`ifndef SYNTH
	function automatic logic [i2cdiv_pkg::CLK_W-1:0] rate_ext_best();
		return {{(i2cdiv_pkg::CLK_W-i2cdiv_pkg::RATE_W){1'b0}}, best_rate_q};
	endfunction

	// An accepted word starts the program.
	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (pc_q == i2cdiv_pkg::STEP_INIT))
		else $error("accepted word did not start the program");

	// The result is only shown while the block is busy.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("done while idle");

	// The multiplier code never leaves its range at the result.
	a_mult_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (mult_index != 2'd3))
		else $error("multiplier code out of range");

	// The reported error matches the reported rate.
	a_err_match: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rate_error == ((rate_ext_best() >= desired_q) ?
			(rate_ext_best() - desired_q) : (desired_q - rate_ext_best()))))
		else $error("rate error does not match achieved rate");

	// The step counter stays inside the program.
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= i2cdiv_pkg::STEP_DONE)
		else $error("step counter outside the program");
`endif

endmodule
